[rtl/pulse_ratio_key_frame_reader_macros.svh]
// assertion macros shared by the key frame reader modules
// no dependencies; included by files that carry assertions
`ifndef PULSE_RATIO_KEY_FRAME_READER_MACROS_SVH
`define PULSE_RATIO_KEY_FRAME_READER_MACROS_SVH

// same-cycle implication under active reset disable
`define PRKFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active reset disable
`define PRKFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prkfr_pkg.sv]
// types, constants and symbol decode function for the key frame reader
// no dependencies; used by every rtl module
package prkfr_pkg;

    localparam int PAIR_LIMIT_DEF = 80;
    localparam int PAIR_W         = 7;

    localparam logic [7:0] REPEAT_RESET = 8'd2;

    localparam logic [1:0] PRESYNC_BEGIN  = 2'd2;
    localparam logic [1:0] PRESYNC_REPEAT = 2'd1;

    localparam logic [7:0] START_INIT    = 8'h0F;
    localparam logic [7:0] START_LOCKED  = 8'h80;
    localparam logic [7:0] START_PATTERN = 8'h01;
    localparam logic [7:0] HUNT_MASK     = 8'h0F;

    localparam logic [2:0] FRAME_BYTES = 3'd4;

    localparam logic [3:0] SYM_THREE = 4'hE;
    localparam logic [3:0] SYM_TWO   = 4'hD;
    localparam logic [3:0] SYM_ONE   = 4'hB;
    localparam logic [3:0] SYM_ZERO  = 4'h7;
    localparam logic [2:0] SYM_BAD   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SYNC = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TIMEOUT  = 3'd1,
        ST_LIMIT    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_BAD_SYM  = 3'd4
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] raw_code;
        logic [15:0] key_code;
    } t_result;

    // one-of-four nibble to two bits, bit 2 set on a bad symbol
    function automatic logic [2:0] sym_decode(input logic [3:0] nib);
        logic [2:0] r;
        case (nib)
            SYM_THREE: r = 3'd3;
            SYM_TWO:   r = 3'd2;
            SYM_ONE:   r = 3'd1;
            SYM_ZERO:  r = 3'd0;
            default:   r = SYM_BAD;
        endcase
        return r;
    endfunction

endpackage

[rtl/prkfr_key_decode.sv]
// decodes a 32-bit raw frame into the 16-bit key and a bad symbol flag
// depends on prkfr_pkg
module prkfr_key_decode (
    input  logic [31:0] i_frame,
    output logic [15:0] o_key,
    output logic        o_bad
);

    logic [3:0] bad_byte;

    for (genvar k = 0; k < 4; k++) begin : g_byte
        logic [7:0] byte_v;
        logic [2:0] d;
        logic [2:0] n;
        assign byte_v = i_frame[31 - 8*k -: 8];
        assign d = prkfr_pkg::sym_decode(byte_v[7:4]);
        assign n = prkfr_pkg::sym_decode(byte_v[3:0]);
        assign o_key[15 - 4*k -: 4] = {d[1:0], n[1:0]};
        assign bad_byte[k] = d[2] | n[2];
    end

    assign o_bad = |bad_byte;

endmodule

[rtl/prkfr_core.sv]
// frame reader state and per-pair step logic
// depends on prkfr_pkg, prkfr_key_decode and the assertion macro header
`include "pulse_ratio_key_frame_reader_macros.svh"

module prkfr_core #(
    parameter int PAIR_LIMIT = prkfr_pkg::PAIR_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_func,
    input  logic [15:0]          i_low_period,
    input  logic [15:0]          i_high_period,
    input  logic [7:0]           i_repeat_count,
    output logic                 o_emit,
    output prkfr_pkg::t_result   o_result
);

    localparam logic [prkfr_pkg::PAIR_W-1:0] PAIR_W_LIMIT = prkfr_pkg::PAIR_W'(PAIR_LIMIT);

    prkfr_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_presync, n_presync;
    logic [7:0]  r_start, n_start;
    logic [2:0]  r_bit, n_bit;
    logic [2:0]  r_byte, n_byte;
    logic [31:0] r_frame, n_frame;
    logic [prkfr_pkg::PAIR_W-1:0] r_pair, n_pair;
    logic [7:0]  r_reads, n_reads;
    logic [31:0] r_first, n_first;

    logic        vbit;
    logic        timeout;
    logic [7:0]  hunt;
    logic [2:0]  bit_inc;
    logic [prkfr_pkg::PAIR_W-1:0] pair_inc;
    logic [31:0] frame_next;
    logic [15:0] dec_key;
    logic        dec_bad;

    assign vbit       = i_low_period < i_high_period;
    assign timeout    = (i_low_period == 16'd0) || (i_high_period == 16'd0);
    assign hunt       = r_start | {7'd0, vbit};
    assign bit_inc    = r_bit + 3'd1;
    assign pair_inc   = r_pair + 1'b1;
    assign frame_next = {r_frame[30:0], vbit};

    prkfr_key_decode u_key_decode (
        .i_frame (frame_next),
        .o_key   (dec_key),
        .o_bad   (dec_bad)
    );

    always_comb begin
        n_phase   = r_phase;
        n_presync = r_presync;
        n_start   = r_start;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_frame   = r_frame;
        n_pair    = r_pair;
        n_reads   = r_reads;
        n_first   = r_first;
        o_emit    = 1'b0;
        o_result  = '{status: prkfr_pkg::ST_OK, raw_code: 32'd0, key_code: 16'd0};
        if (i_step) begin
            if (i_func) begin
                n_reads   = 8'd0;
                n_phase   = prkfr_pkg::PH_SYNC;
                n_presync = prkfr_pkg::PRESYNC_BEGIN;
                n_start   = prkfr_pkg::START_INIT;
                n_bit     = 3'd0;
                n_byte    = 3'd0;
                n_frame   = 32'd0;
                n_pair    = '0;
            end else if (r_phase != prkfr_pkg::PH_IDLE) begin
                if (timeout) begin
                    o_emit          = 1'b1;
                    o_result.status = prkfr_pkg::ST_TIMEOUT;
                end else if (r_phase == prkfr_pkg::PH_SYNC) begin
                    n_presync = r_presync - 2'd1;
                    if (r_presync == 2'd1) begin
                        n_phase = prkfr_pkg::PH_DATA;
                    end
                end else begin
                    if (!r_start[7]) begin
                        if (hunt == prkfr_pkg::START_PATTERN) begin
                            n_start = prkfr_pkg::START_LOCKED;
                        end else begin
                            n_start = {hunt[6:0], 1'b0} & prkfr_pkg::HUNT_MASK;
                        end
                    end else begin
                        n_frame = frame_next;
                        n_bit   = bit_inc;
                        if (bit_inc == 3'd0) begin
                            n_byte = r_byte + 3'd1;
                        end
                    end
                    n_pair = pair_inc;
                    if (pair_inc == PAIR_W_LIMIT) begin
                        o_emit          = 1'b1;
                        o_result.status = prkfr_pkg::ST_LIMIT;
                    end else if (n_byte == prkfr_pkg::FRAME_BYTES) begin
                        if (r_reads == 8'd0) begin
                            n_first = frame_next;
                        end
                        if (r_reads != 8'd0 && r_first != frame_next) begin
                            o_emit          = 1'b1;
                            o_result.status = prkfr_pkg::ST_MISMATCH;
                        end else begin
                            n_reads = r_reads + 8'd1;
                            if (n_reads != i_repeat_count) begin
                                n_phase   = prkfr_pkg::PH_SYNC;
                                n_presync = prkfr_pkg::PRESYNC_REPEAT;
                                n_start   = prkfr_pkg::START_INIT;
                                n_bit     = 3'd0;
                                n_byte    = 3'd0;
                                n_frame   = 32'd0;
                                n_pair    = '0;
                            end else if (dec_bad) begin
                                o_emit          = 1'b1;
                                o_result.status = prkfr_pkg::ST_BAD_SYM;
                            end else begin
                                o_emit            = 1'b1;
                                o_result.raw_code = frame_next;
                                o_result.key_code = dec_key;
                            end
                        end
                    end
                end
            end
        end
        if (o_emit) begin
            n_phase = prkfr_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= prkfr_pkg::PH_IDLE;
            r_presync <= 2'd0;
            r_start   <= prkfr_pkg::START_INIT;
            r_bit     <= 3'd0;
            r_byte    <= 3'd0;
            r_frame   <= 32'd0;
            r_pair    <= '0;
            r_reads   <= 8'd0;
        end else begin
            r_phase   <= n_phase;
            r_presync <= n_presync;
            r_start   <= n_start;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_frame   <= n_frame;
            r_pair    <= n_pair;
            r_reads   <= n_reads;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
    end

    `PRKFR_ASSERT_NEXT(a_emit_idles, i_step && o_emit, r_phase == prkfr_pkg::PH_IDLE, "phase not idle after result")
    `PRKFR_ASSERT_NEXT(a_begin_sync, i_step && i_func, r_phase == prkfr_pkg::PH_SYNC && r_presync == prkfr_pkg::PRESYNC_BEGIN && r_reads == 8'd0, "begin did not restart read")
    `PRKFR_ASSERT_NOW(a_fail_zero, o_emit && o_result.status != prkfr_pkg::ST_OK, o_result.raw_code == 32'd0 && o_result.key_code == 16'd0, "failed read carries code")
    `PRKFR_ASSERT_NOW(a_byte_range, r_phase == prkfr_pkg::PH_DATA, r_byte < prkfr_pkg::FRAME_BYTES, "byte count past frame")

endmodule

[rtl/pulse_ratio_key_frame_reader.sv]
// reader of a pulse-ratio key frame from measured low/high period pairs
// slave stream carries pairs and begin commands, master stream carries one result per read
// tdata of the slave side: low_period, high_period; tuser: func (1 = begin new read)
// tdata of the master side: status, raw_code, key_code, zero padded to 56 bits
// repeat_count is written through the cfg channel, which is always ready
// an accepted transaction lands in an input register; stepping it updates the frame
// logic and, when a read ends, loads the output register, so a result shows on
// m_axis_tvalid from the output register once its last pair has been stepped
// throughput is one transaction per cycle; the input register frees each cycle its
// item is stepped, and stepping needs the output register empty or being taken
// while the receiver stalls with a result pending, pairs behind it stop in the input
// register and s_axis_tready drops
// reset idles the reader, empties both registers and sets repeat_count to 2
// pairs seen while idle are dropped; a begin aborts any read in progress
// depends on prkfr_pkg, prkfr_core, prkfr_key_decode and the macro header
`include "pulse_ratio_key_frame_reader_macros.svh"

module pulse_ratio_key_frame_reader #(
    parameter int PAIR_LIMIT = prkfr_pkg::PAIR_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // low_period[15:0], high_period[31:16]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // status[2:0], raw_code[34:3], key_code[50:35]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic        r_in_valid;
    logic        r_in_func;
    logic [15:0] r_in_low;
    logic [15:0] r_in_high;
    logic        r_out_valid;
    prkfr_pkg::t_result r_out;
    logic [7:0]  r_repeat;

    logic        step;
    logic        in_fire;
    logic        emit;
    prkfr_pkg::t_result result;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    prkfr_core #(
        .PAIR_LIMIT (PAIR_LIMIT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_func         (r_in_func),
        .i_low_period   (r_in_low),
        .i_high_period  (r_in_high),
        .i_repeat_count (r_repeat),
        .o_emit         (emit),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_repeat    <= prkfr_pkg::REPEAT_RESET;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_repeat <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_func <= s_axis_tuser[0];
            r_in_low  <= s_axis_tdata[15:0];
            r_in_high <= s_axis_tdata[31:16];
        end
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.key_code, r_out.raw_code, r_out.status};

    `PRKFR_ASSERT_NEXT(a_in_kept, r_in_valid && !step, r_in_valid && $stable(r_in_low) && $stable(r_in_func), "pending transaction dropped")
    `PRKFR_ASSERT_NOW(a_no_overwrite, step && emit, !r_out_valid || m_axis_tready, "result overwrites pending result")
    `PRKFR_ASSERT_NEXT(a_result_shown, step && emit, r_out_valid, "result not registered")

endmodule

[dv/testbench.sv]
// self-checking testbench for pulse_ratio_key_frame_reader: random key frame reads with gaps and stalls
// predicts status, raw frame and decoded key per read and compares every result transaction
// depends on prkfr_pkg and the rtl of pulse_ratio_key_frame_reader
module testbench;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [6:0] PAIR_MAX = 7'(prkfr_pkg::PAIR_LIMIT_DEF);

    typedef struct packed {
        logic        begin_cmd;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        counted;
    } t_line_pair;

    typedef enum int {
        RUN_OK,
        RUN_MISMATCH,
        RUN_BAD_SYMBOL,
        RUN_TIMEOUT,
        RUN_LIMIT,
        RUN_LIMIT_AT_END,
        RUN_ABORT
    } t_run_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    // reader state as predicted
    logic [7:0]  repeat_reg = prkfr_pkg::REPEAT_RESET;
    prkfr_pkg::t_phase rd_phase = prkfr_pkg::PH_IDLE;
    logic [1:0]  sync_left = '0;
    logic [7:0]  hunt_window = prkfr_pkg::START_INIT;
    logic [2:0]  bit_cnt = '0;
    logic [2:0]  byte_cnt = '0;
    logic [31:0] frame_bits = '0;
    logic [6:0]  pairs_counted = '0;
    logic [7:0]  reads_matched = '0;
    logic [31:0] first_code = '0;

    prkfr_pkg::t_result read_outcomes[$];
    t_line_pair  line_pairs[$];
    t_line_pair  read_buf[$];
    t_line_pair  next_pair;

    bit          s_item_taken = 1'b0;
    bit          cfg_taken = 1'b0;
    bit          failed = 1'b0;
    int          send_wait = 0;
    int          send_burst = 0;
    int          recv_wait = 0;
    int          recv_burst = 0;
    int          cycle_count = 0;
    int          items_queued = 0;

    pulse_ratio_key_frame_reader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- prediction ----------------

    function automatic int symbol_bits(input logic [3:0] nib);
        case (nib)
            prkfr_pkg::SYM_THREE: return 3;
            prkfr_pkg::SYM_TWO:   return 2;
            prkfr_pkg::SYM_ONE:   return 1;
            prkfr_pkg::SYM_ZERO:  return 0;
            default:              return -1;
        endcase
    endfunction

    task automatic restart_read(input logic [1:0] syncs);
        rd_phase      = prkfr_pkg::PH_SYNC;
        sync_left     = syncs;
        hunt_window   = prkfr_pkg::START_INIT;
        bit_cnt       = '0;
        byte_cnt      = '0;
        frame_bits    = '0;
        pairs_counted = '0;
    endtask

    task automatic post_result(input prkfr_pkg::t_status st, input logic [31:0] raw,
                               input logic [15:0] key);
        read_outcomes.push_back('{status: st, raw_code: raw, key_code: key});
        rd_phase = prkfr_pkg::PH_IDLE;
    endtask

    task automatic track_key_read(input logic begin_cmd, input logic [15:0] lo,
                                  input logic [15:0] hi);
        logic       line_bit;
        logic [7:0] window_next;
        logic [7:0] byte_val;
        logic [15:0] key;
        int         hi_sym;
        int         lo_sym;
        int         k;
        bit         bad;
        if (begin_cmd) begin
            reads_matched = '0;
            restart_read(prkfr_pkg::PRESYNC_BEGIN);
        end else if (rd_phase != prkfr_pkg::PH_IDLE) begin
            if (lo == 0 || hi == 0) begin
                post_result(prkfr_pkg::ST_TIMEOUT, '0, '0);
            end else if (rd_phase == prkfr_pkg::PH_SYNC) begin
                sync_left = sync_left - 2'd1;
                if (sync_left == 0) rd_phase = prkfr_pkg::PH_DATA;
            end else begin
                line_bit = (lo < hi);
                if (!hunt_window[7]) begin
                    window_next = hunt_window | {7'b0, line_bit};
                    if (window_next == prkfr_pkg::START_PATTERN)
                        hunt_window = prkfr_pkg::START_LOCKED;
                    else hunt_window = (window_next << 1) & prkfr_pkg::HUNT_MASK;
                end else begin
                    frame_bits = {frame_bits[30:0], line_bit};
                    bit_cnt = bit_cnt + 3'd1;
                    if (bit_cnt == 0) byte_cnt = byte_cnt + 3'd1;
                end
                pairs_counted = pairs_counted + 7'd1;
                if (pairs_counted == PAIR_MAX) begin
                    post_result(prkfr_pkg::ST_LIMIT, '0, '0);
                end else if (byte_cnt == prkfr_pkg::FRAME_BYTES) begin
                    if (reads_matched != 0 && first_code != frame_bits) begin
                        post_result(prkfr_pkg::ST_MISMATCH, '0, '0);
                    end else begin
                        if (reads_matched == 0) first_code = frame_bits;
                        reads_matched = reads_matched + 8'd1;
                        if (reads_matched != repeat_reg) begin
                            restart_read(prkfr_pkg::PRESYNC_REPEAT);
                        end else begin
                            key = '0;
                            bad = 1'b0;
                            for (k = 0; k < 4; k++) begin
                                byte_val = first_code[31 - 8 * k -: 8];
                                hi_sym = symbol_bits(byte_val[7:4]);
                                lo_sym = symbol_bits(byte_val[3:0]);
                                if (hi_sym < 0 || lo_sym < 0) bad = 1'b1;
                                key = {key[11:0], 2'(hi_sym), 2'(lo_sym)};
                            end
                            if (bad) post_result(prkfr_pkg::ST_BAD_SYM, '0, '0);
                            else post_result(prkfr_pkg::ST_OK, first_code, key);
                        end
                    end
                end
            end
        end
    endtask

    task automatic check_outcome();
        prkfr_pkg::t_result want;
        logic [2:0]  got_status;
        logic [31:0] got_raw;
        logic [15:0] got_key;
        got_status = m_axis_tdata[2:0];
        got_raw    = m_axis_tdata[34:3];
        got_key    = m_axis_tdata[50:35];
        if (read_outcomes.size() == 0) begin
            $error("unexpected result transaction: status %0d raw %h key %h",
                   got_status, got_raw, got_key);
            failed = 1'b1;
        end else begin
            want = read_outcomes.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                failed = 1'b1;
            end
            if (got_raw !== want.raw_code) begin
                $error("raw_code: expected %h, got %h", want.raw_code, got_raw);
                failed = 1'b1;
            end
            if (got_key !== want.key_code) begin
                $error("key_code: expected %h, got %h", want.key_code, got_key);
                failed = 1'b1;
            end
        end
    endtask

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (!i_rst_n) begin
            s_item_taken = 1'b0;
            cfg_taken = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_outcome();
            s_item_taken = s_axis_tvalid && s_axis_tready;
            if (s_item_taken)
                track_key_read(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16]);
            cfg_taken = i_cfg_valid && o_cfg_ready;
            if (cfg_taken) repeat_reg = i_cfg_data;
        end
    end

    // ---------------- driver and receiver ----------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || s_item_taken)) begin
            if (send_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                send_wait--;
            end else if (line_pairs.size() != 0) begin
                next_pair = line_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_pair.begin_cmd;
                s_axis_tdata  <= {next_pair.hi, next_pair.lo};
                if (send_burst > 0) begin
                    send_burst--;
                end else begin
                    send_wait = idle_len();
                    if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(20, 80);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_wait > 0) begin
            m_axis_tready <= 1'b0;
            recv_wait--;
        end else begin
            m_axis_tready <= 1'b1;
            if (recv_burst > 0) begin
                recv_burst--;
            end else begin
                recv_wait = idle_len();
                if ($urandom_range(0, 29) == 0) recv_burst = $urandom_range(20, 80);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_pair(input logic begin_cmd, input logic [15:0] lo,
                             input logic [15:0] hi, input logic counted);
        line_pairs.push_back('{begin_cmd: begin_cmd, lo: lo, hi: hi, counted: counted});
        if (counted) items_queued++;
    endtask

    function automatic logic [15:0] rand_period();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h0001;
        if (r == 1) return 16'hFFFF;
        if (r < 5) return 16'($urandom_range(1, 300));
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic t_line_pair bit_pair(input logic line_bit);
        logic [15:0] a;
        logic [15:0] b;
        a = rand_period();
        b = rand_period();
        if ($urandom_range(0, 7) == 0) b = a;
        else if ($urandom_range(0, 7) == 0 && a != 16'hFFFF) b = a + 16'd1;
        if (line_bit && a == b) begin
            if (a == 16'hFFFF) a = a - 16'd1;
            else b = b + 16'd1;
        end
        if (line_bit == (a < b)) return '{begin_cmd: 1'b0, lo: a, hi: b, counted: 1'b1};
        return '{begin_cmd: 1'b0, lo: b, hi: a, counted: 1'b1};
    endfunction

    function automatic t_line_pair timeout_pair();
        int r;
        r = $urandom_range(0, 2);
        return '{begin_cmd: 1'b0, lo: (r == 1) ? rand_period() : 16'h0,
                 hi: (r == 0) ? rand_period() : 16'h0, counted: 1'b1};
    endfunction

    function automatic logic [31:0] make_code(input bit well_formed);
        logic [31:0] code;
        logic [3:0]  nib;
        int          n;
        for (n = 0; n < 8; n++) begin
            case ($urandom_range(0, 3))
                0:       code[4 * n +: 4] = prkfr_pkg::SYM_THREE;
                1:       code[4 * n +: 4] = prkfr_pkg::SYM_TWO;
                2:       code[4 * n +: 4] = prkfr_pkg::SYM_ONE;
                default: code[4 * n +: 4] = prkfr_pkg::SYM_ZERO;
            endcase
        end
        if (!well_formed) begin
            n = $urandom_range(0, 7);
            do nib = 4'($urandom_range(0, 15)); while (symbol_bits(nib) >= 0);
            code[4 * n +: 4] = nib;
        end
        return code;
    endfunction

    // sync pairs, hunt prefix, start nibble and 32 data bits; a negative ones count
    // gives a random hunt prefix
    task automatic build_read(input logic [31:0] code, input int syncs, input int ones);
        int i;
        repeat (syncs) read_buf.push_back(bit_pair(1'($urandom_range(0, 1))));
        if (ones < 0) begin
            repeat ($urandom_range(1, 6)) read_buf.push_back(bit_pair(1'($urandom_range(0, 1))));
        end else begin
            read_buf.push_back(bit_pair(1'($urandom_range(0, 1))));
            repeat (ones) read_buf.push_back(bit_pair(1'b1));
        end
        repeat (3) read_buf.push_back(bit_pair(1'b0));
        read_buf.push_back(bit_pair(1'b1));
        for (i = 31; i >= 0; i--) read_buf.push_back(bit_pair(code[i]));
    endtask

    function automatic int hunt_ones();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
        return -1;
    endfunction

    function automatic t_run_style pick_style(input bit allow_abort);
        int r;
        r = $urandom_range(0, allow_abort ? 99 : 91);
        if (r < 35) return RUN_OK;
        if (r < 47) return RUN_MISMATCH;
        if (r < 59) return RUN_BAD_SYMBOL;
        if (r < 74) return RUN_TIMEOUT;
        if (r < 80) return RUN_LIMIT;
        if (r < 92) return RUN_LIMIT_AT_END;
        return RUN_ABORT;
    endfunction

    task automatic queue_series(input t_run_style style, input int need);
        logic [31:0] code;
        int          last;
        int          f;
        int          r;
        int          syncs;
        int          cut;
        bit          again;
        do begin
            again = 1'b0;
            if (need > 8 && (style == RUN_OK || style == RUN_BAD_SYMBOL)) style = RUN_TIMEOUT;
            if (need < 2 && style == RUN_MISMATCH) style = RUN_OK;
            code = make_code(style != RUN_BAD_SYMBOL);
            last = (need < 4) ? need - 1 : 3;
            if (style == RUN_OK || style == RUN_BAD_SYMBOL) f = need - 1;
            else if (style == RUN_MISMATCH) f = $urandom_range(1, last);
            else f = $urandom_range(0, last);
            push_pair(1'b1, rand_period(), rand_period(), 1'b1);
            for (r = 0; r <= f; r++) begin
                read_buf.delete();
                syncs = (r == 0) ? 2 : 1;
                if (r != f || style == RUN_OK || style == RUN_BAD_SYMBOL) begin
                    build_read(code, syncs, hunt_ones());
                end else begin
                    case (style)
                        RUN_MISMATCH: begin
                            build_read(code ^ (32'h1 << $urandom_range(0, 31)), syncs,
                                       hunt_ones());
                        end
                        RUN_LIMIT: begin
                            repeat (syncs) read_buf.push_back(bit_pair(1'b1));
                            repeat (prkfr_pkg::PAIR_LIMIT_DEF + $urandom_range(0, 4))
                                read_buf.push_back(bit_pair(1'b1));
                        end
                        RUN_LIMIT_AT_END: begin
                            // frame completes on the very pair that hits the limit
                            build_read(code, syncs, prkfr_pkg::PAIR_LIMIT_DEF - 37);
                        end
                        default: begin
                            build_read(code, syncs, hunt_ones());
                            cut = $urandom_range(0, read_buf.size() - 1);
                            while (read_buf.size() > cut) void'(read_buf.pop_back());
                            if (style == RUN_TIMEOUT) read_buf.push_back(timeout_pair());
                        end
                    endcase
                end
                foreach (read_buf[i]) push_pair(1'b0, read_buf[i].lo, read_buf[i].hi, 1'b1);
            end
            if (style == RUN_ABORT) begin
                again = 1'b1;
                style = pick_style(1'b0);
            end
        end while (again);
    endtask

    task automatic queue_idle_noise();
        t_line_pair p;
        repeat ($urandom_range(1, 4)) begin
            p = ($urandom_range(0, 2) == 0) ? timeout_pair() : bit_pair(1'($urandom_range(0, 1)));
            push_pair(1'b0, p.lo, p.hi, 1'b0);
        end
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (line_pairs.size() != 0 || s_axis_tvalid || read_outcomes.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_repeat(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int         phase_no;
        int         need;
        int         s;
        logic [7:0] rep;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pairs while idle, timeouts in sync, hunt and data, abort during sync, field extremes
        push_pair(1'b0, 16'hFFFF, 16'h0001, 1'b0);
        push_pair(1'b0, 16'h0000, 16'h0000, 1'b0);
        push_pair(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        push_pair(1'b0, 16'h0001, 16'hFFFF, 1'b1);
        push_pair(1'b0, 16'h0000, 16'hFFFF, 1'b1);
        push_pair(1'b1, 16'h0000, 16'h0000, 1'b1);
        push_pair(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        push_pair(1'b0, 16'h0001, 16'h0001, 1'b1);
        push_pair(1'b0, 16'hFFFF, 16'h0000, 1'b1);
        push_pair(1'b1, 16'h5555, 16'hAAAA, 1'b1);
        push_pair(1'b0, 16'h8000, 16'h7FFF, 1'b1);
        push_pair(1'b1, 16'hAAAA, 16'h5555, 1'b1);
        push_pair(1'b0, 16'h7FFF, 16'h8000, 1'b1);
        push_pair(1'b0, 16'h1234, 16'h1234, 1'b1);
        push_pair(1'b0, 16'h0001, 16'h0002, 1'b1);
        push_pair(1'b0, 16'h0002, 16'h0001, 1'b1);
        push_pair(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        push_pair(1'b0, 16'h0009, 16'h0008, 1'b1);
        push_pair(1'b0, 16'hFFFE, 16'hFFFF, 1'b1);
        push_pair(1'b0, 16'h0003, 16'h0004, 1'b1);
        push_pair(1'b0, 16'h0004, 16'h0003, 1'b1);
        push_pair(1'b0, 16'h0000, 16'h0000, 1'b1);
        push_pair(1'b0, 16'h0001, 16'hFFFF, 1'b0);
        for (s = RUN_OK; s <= RUN_ABORT; s++) queue_series(t_run_style'(s), 2);
        wait_quiet();

        phase_no = 1;
        do begin
            case (phase_no)
                1: rep = 8'd1;
                2: rep = 8'd255;
                3: rep = 8'd0;
                4: rep = 8'd3;
                default: begin
                    if ($urandom_range(0, 5) == 0) rep = 8'($urandom_range(5, 12));
                    else rep = 8'($urandom_range(1, 3));
                end
            endcase
            write_repeat(rep);
            need = (rep == 0) ? 256 : int'(rep);
            repeat (2) begin
                if ($urandom_range(0, 4) == 0) queue_idle_noise();
                queue_series(pick_style(1'b1), need);
            end
            wait_quiet();
            phase_no++;
        end while (phase_no <= 4 || items_queued < 1450);

        if (!failed && read_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
